[rtl/core/dsympred_pkg.sv]
package dsympred_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_OUTCOMES_DEF = 256;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int SYM_W    = 8;
    localparam int PRIOR_W  = 16;
    localparam int ACTIVE_W = 9;
    localparam int SEEN_W   = 9;
    localparam int PROB_W   = 16;
    localparam int PROD_W   = SEEN_W + 1 + PRIOR_W;
    localparam int QUOT_W   = PROB_W + 1;
    localparam int STEP_W   = 5;

    // Register reset values
    localparam logic [PRIOR_W-1:0]  PRIOR_RESET  = 16'd256;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_WEIGHT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_OUTCOMES = 1'b1;

    // Divider step counts: fraction bits, and integer quotient bits of a 17-bit value
    localparam logic [STEP_W-1:0] FRAC_STEPS = 5'd16;
    localparam logic [STEP_W-1:0] INT_STEPS  = 5'd17;

    localparam logic [QUOT_W-1:0] QUOT_ONE = 17'h10000;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/core/dsympred_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module dsympred_div
    import dsympred_pkg::*;
#(
    parameter int ZW = 41
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_cmd_t          cmd,
    input  logic [ZW-1:0]     rem_init,
    input  logic [ZW-1:0]     divisor,
    input  logic [QUOT_W-1:0] dividend,
    output div_stat_t         stat,
    output logic [QUOT_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ZW-1:0]     rem_reg;
    logic [ZW-1:0]     den_reg;
    logic [QUOT_W-1:0] dvd_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [ZW:0]   rem_shift;
    logic          fits;
    logic [ZW-1:0] rem_next;

    // Shift in the next dividend bit and try a subtract
    assign rem_shift = {rem_reg, dvd_reg[QUOT_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_next  = fits ? ZW'(rem_shift - {1'b0, den_reg}) : rem_shift[ZW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                step_reg <= cmd.steps;
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg  <= rem_init;
            den_reg  <= divisor;
            dvd_reg  <= dividend;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

[rtl/core/dirichlet_symbol_predictor.sv]
// Adaptive symbol predictor: each item carries one symbol index and yields one result, the
// probability (Q0.16, rounded down, saturated at 65535) that the running Dirichlet-multinomial
// estimate gave that symbol before the item, after which the symbol is counted. A symbol
// already seen runs the shared radix-2 divider at most once; an unseen symbol runs it up to
// twice (16 fraction bits for prior/Z, then 17 integer bits for the split over the
// remaining unseen outcomes). Zero mass, a seen ratio that saturates, or an unseen prior
// equal to Z with no unseen outcomes left skip a division; an index beyond the count store
// is answered zero and not counted. s_ready is high only between items. A finished result
// sits in the output register, so the next item is accepted while it waits. Reset clears
// every count at once through per-entry valid bits: no clearing pass, the block is ready
// right after reset. Write prior_weight (8.8) and active_outcomes only while the block is idle.
module dirichlet_symbol_predictor
    import dsympred_pkg::*;
#(
    parameter int NUM_OUTCOMES = NUM_OUTCOMES_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PRIOR_W-1:0]   cfg_wdata,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SYM_W-1:0]     s_symbol_index,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PROB_W-1:0]    m_probability
);

    // Only the first 256 outcomes are reachable through an 8-bit index
    localparam int STORE_DEPTH = (NUM_OUTCOMES < (1 << SYM_W)) ? NUM_OUTCOMES : (1 << SYM_W);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // Z = (1+seen)*prior + total*256 needs the wider of both terms plus a carry
    localparam int ZW = ((COUNT_WIDTH + 8 > PROD_W) ? COUNT_WIDTH + 8 : PROD_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ZSUM,
        S_PREP,
        S_DIV1,
        S_SCALE,
        S_DIV2,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [PRIOR_W-1:0]     prior_reg;
    logic [ACTIVE_W-1:0]    active_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [SEEN_W-1:0]      seen_reg;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   rd_valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ZW-1:0]          z_reg;
    logic [ZW-1:0]          num_reg;
    logic [QUOT_W-1:0]      t_reg;
    logic [PROB_W-1:0]      prob_reg;
    logic                   m_valid_reg;
    logic [PROB_W-1:0]      m_prob_reg;

    // Count store
    logic [COUNT_WIDTH-1:0] cnt_mem [STORE_DEPTH];

    logic                   in_accept;
    logic                   in_range;
    logic [ADDR_W-1:0]      s_addr;
    logic [SEEN_W:0]        seen_p1;
    logic [PROD_W-1:0]      prod_next;
    logic [ZW-1:0]          z_next;
    logic [ZW-1:0]          seen_num;
    logic                   cnt_seen;
    logic                   z_zero;
    logic                   num_ge_z;
    logic                   more_unseen;
    logic [ACTIVE_W-1:0]    unseen_left;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [PROB_W-1:0]      quot_sat;
    logic [PROB_W-1:0]      t_sat;

    div_cmd_t               div_cmd;
    div_stat_t              div_stat;
    logic [ZW-1:0]          div_rem_init;
    logic [ZW-1:0]          div_divisor;
    logic [QUOT_W-1:0]      div_dividend;
    logic [QUOT_W-1:0]      div_quot;

    assign in_accept = s_valid && s_ready;
    assign in_range  = 32'(s_symbol_index) < 32'(NUM_OUTCOMES);
    assign s_addr    = s_symbol_index[ADDR_W-1:0];

    assign seen_p1   = {1'b0, seen_reg} + 1'b1;
    assign prod_next = PROD_W'(seen_p1) * PROD_W'(prior_reg);
    assign z_next    = ZW'(prod_reg) + ZW'({total_reg, 8'd0});
    assign seen_num  = ZW'({cnt_reg, 8'd0}) + ZW'(prior_reg);

    assign cnt_seen    = cnt_reg != '0;
    assign z_zero      = z_reg == '0;
    assign num_ge_z    = num_reg >= z_reg;
    assign more_unseen = 10'(active_reg) > 10'(seen_reg);
    assign unseen_left = ACTIVE_W'(active_reg - seen_reg);
    assign cnt_inc     = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    // Clamp a 17-bit quotient to Q0.16
    assign quot_sat = div_quot[QUOT_W-1] ? '1 : div_quot[PROB_W-1:0];
    assign t_sat    = t_reg[QUOT_W-1] ? '1 : t_reg[PROB_W-1:0];

    // Divider command: fraction of num/Z from the prep step, integer t/U from the scale step
    always_comb begin
        div_cmd.start = ((state_reg == S_PREP) && !z_zero && !num_ge_z)
                     || ((state_reg == S_SCALE) && more_unseen);
        div_cmd.steps = (state_reg == S_SCALE) ? INT_STEPS : FRAC_STEPS;
        div_rem_init  = (state_reg == S_SCALE) ? '0 : num_reg;
        div_divisor   = (state_reg == S_SCALE) ? ZW'(unseen_left) : z_reg;
        div_dividend  = (state_reg == S_SCALE) ? t_reg : '0;
    end

    dsympred_div #(
        .ZW(ZW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Count store: read on acceptance, write back the bumped count in the update step
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPDATE) begin
            cnt_mem[addr_reg] <= cnt_inc;
        end
        if (in_accept) begin
            rd_data_reg <= cnt_mem[s_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            prior_reg   <= PRIOR_RESET;
            active_reg  <= ACTIVE_RESET;
            total_reg   <= '0;
            seen_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRIOR_WEIGHT:    prior_reg  <= cfg_wdata;
                    CFG_ACTIVE_OUTCOMES: active_reg <= cfg_wdata[ACTIVE_W-1:0];
                    default: ;
                endcase
            end

            // Drop the held result once it is taken; the output step reloads it itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        addr_reg     <= s_addr;
                        rd_valid_reg <= valid_reg[s_addr];
                        if (in_range) begin
                            state_reg <= S_READ;
                        end else begin
                            // Outside the store: answer zero, leave the state alone
                            prob_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    // An entry never written since reset reads as zero
                    cnt_reg   <= rd_valid_reg ? rd_data_reg : '0;
                    prod_reg  <= prod_next;
                    state_reg <= S_ZSUM;
                end
                S_ZSUM: begin
                    z_reg     <= z_next;
                    num_reg   <= cnt_seen ? seen_num : ZW'(prior_reg);
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    if (z_zero) begin
                        // No mass at all
                        prob_reg  <= '0;
                        state_reg <= S_UPDATE;
                    end else if (num_ge_z) begin
                        if (cnt_seen) begin
                            prob_reg  <= '1;
                            state_reg <= S_UPDATE;
                        end else begin
                            // Unseen with prior equal to Z: the scaled ratio is exactly one
                            t_reg     <= QUOT_ONE;
                            state_reg <= S_SCALE;
                        end
                    end else begin
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_stat.done) begin
                        if (cnt_seen) begin
                            prob_reg  <= div_quot[PROB_W-1:0];
                            state_reg <= S_UPDATE;
                        end else begin
                            t_reg     <= div_quot;
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    // Split over the outcomes not yet seen, if any remain
                    if (more_unseen) begin
                        state_reg <= S_DIV2;
                    end else begin
                        prob_reg  <= t_sat;
                        state_reg <= S_UPDATE;
                    end
                end
                S_DIV2: begin
                    if (div_stat.done) begin
                        prob_reg  <= quot_sat;
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    valid_reg[addr_reg] <= 1'b1;
                    if (total_reg != '1) begin
                        total_reg <= total_reg + 1'b1;
                    end
                    if (!cnt_seen && (seen_reg != '1)) begin
                        seen_reg <= seen_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_prob_reg  <= prob_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_probability = m_prob_reg;

`ifndef NO_ASSERTIONS
    a_seen_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> seen_reg >= $past(seen_reg))
        else $error("seen symbol count went down");

    a_total_only_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_UPDATE |=> total_reg == $past(total_reg))
        else $error("total count changed outside the update step");

    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_ready)
        else $error("input ready while the divider is busy");

    a_div_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> $past(div_stat.busy))
        else $error("divider done without a running division");

    a_result_from_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output step");
`endif

endmodule

[bench/dirichlet_symbol_predictor_tb.sv]
module dirichlet_symbol_predictor_tb;
    import dsympred_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PRIOR_WEIGHT;
    logic [PRIOR_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [SYM_W-1:0]     s_symbol_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PROB_W-1:0]    m_probability;

    dirichlet_symbol_predictor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol_index (s_symbol_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_probability  (m_probability)
    );

    // Symbols waiting to be offered; the front one is on the bus while s_valid is high.
    logic [SYM_W-1:0]  pending_symbols[$];
    // Probabilities owed by the block, oldest first.
    logic [PROB_W-1:0] expected_probabilities[$];

    // Our own copy of the estimator state and its two registers.
    logic [CNT_W-1:0]    hit_counts[NUM_OUTCOMES_DEF];
    logic [CNT_W-1:0]    observed_total;
    logic [SEEN_W-1:0]   distinct_seen;
    logic [PRIOR_W-1:0]  prior_q8;
    logic [ACTIVE_W-1:0] active_limit;

    int   send_idle_pct = 20;
    int   recv_idle_pct = 46;
    int   error_count = 0;
    logic symbol_taken = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Work out the probability the estimator gives this symbol, then count it.
    function automatic logic [PROB_W-1:0] predict_probability(input logic [SYM_W-1:0] sym);
        logic [63:0]      mass;
        logic [63:0]      numer;
        logic [63:0]      quot;
        logic [CNT_W-1:0] cnt;
        cnt  = hit_counts[sym];
        // Z = (1 + seen) * prior + total, all in 8.8
        mass = (64'(distinct_seen) + 64'd1) * 64'(prior_q8) + (64'(observed_total) << 8);
        if (mass == 64'd0) begin
            // no mass at all: answer zero
            quot = 64'd0;
        end else if (cnt != '0) begin
            numer = (64'(cnt) << 8) + 64'(prior_q8);
            quot  = (numer >= mass) ? 64'hFFFF : (numer << 16) / mass;
        end else begin
            // unseen: split prior/Z over the outcomes not yet seen, if any remain
            quot = (64'(prior_q8) << 16) / mass;
            if (active_limit > distinct_seen)
                quot = quot / 64'(active_limit - distinct_seen);
            if (quot > 64'hFFFF)
                quot = 64'hFFFF;
        end
        if (cnt == '0 && distinct_seen != '1)
            distinct_seen = distinct_seen + 1'b1;
        if (cnt != '1)
            hit_counts[sym] = cnt + 1'b1;
        if (observed_total != '1)
            observed_total = observed_total + 1'b1;
        return quot[PROB_W-1:0];
    endfunction

    // Driver: hold an offered item until taken, otherwise offer the next one or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !symbol_taken) begin
            // hold: valid stays up with the same symbol
        end else if (pending_symbols.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            s_valid        <= 1'b1;
            s_symbol_index <= pending_symbols[0];
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver backpressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: check results first, then predict for a newly taken item.
    always @(posedge aclk) begin
        symbol_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_probabilities.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, probability %0d", $time, m_probability);
            end else if (expected_probabilities[0] != m_probability) begin
                error_count++;
                $display("%0t: probability mismatch: expected %0d, actual %0d",
                         $time, expected_probabilities[0], m_probability);
                void'(expected_probabilities.pop_front());
            end else begin
                void'(expected_probabilities.pop_front());
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_probabilities.push_back(predict_probability(s_symbol_index));
            void'(pending_symbols.pop_front());
        end
    end

    // Write one register; the block is idle whenever this is called.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PRIOR_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRIOR_WEIGHT)
            prior_q8 = value;
        else
            active_limit = value[ACTIVE_W-1:0];
    endtask

    // Drain every item and result, then give the divider time to go quiet.
    task automatic wait_drained();
        while (pending_symbols.size() != 0 || expected_probabilities.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    initial begin
        logic [SYM_W-1:0]   sym_draw;
        logic [SYM_W-1:0]   hot_base;
        logic [PRIOR_W-1:0] prior_pick;
        logic [PRIOR_W-1:0] active_pick;
        for (int i = 0; i < NUM_OUTCOMES_DEF; i++)
            hit_counts[i] = '0;
        observed_total = '0;
        distinct_seen  = '0;
        prior_q8       = PRIOR_RESET;
        active_limit   = ACTIVE_RESET;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Zero prior with nothing counted gives zero mass; a repeat then saturates.
        write_register(CFG_PRIOR_WEIGHT, 16'h0000);
        write_register(CFG_ACTIVE_OUTCOMES, 16'h0100);
        pending_symbols.push_back(8'd0);
        pending_symbols.push_back(8'd0);
        pending_symbols.push_back(8'd255);
        wait_drained();

        // Largest prior, one active outcome: no unseen outcomes left, and
        // symbols at or above the active count.
        write_register(CFG_PRIOR_WEIGHT, 16'hFFFF);
        write_register(CFG_ACTIVE_OUTCOMES, 16'h0001);
        pending_symbols.push_back(8'd7);
        pending_symbols.push_back(8'd0);
        pending_symbols.push_back(8'd255);
        pending_symbols.push_back(8'd7);
        wait_drained();

        // Unit prior over all outcomes: unseen symbols split the remaining mass.
        write_register(CFG_PRIOR_WEIGHT, 16'h0100);
        write_register(CFG_ACTIVE_OUTCOMES, 16'h0100);
        pending_symbols.push_back(8'h55);
        pending_symbols.push_back(8'hAA);
        pending_symbols.push_back(8'h0F);
        pending_symbols.push_back(8'hF0);
        pending_symbols.push_back(8'd128);
        pending_symbols.push_back(8'd1);
        pending_symbols.push_back(8'd254);
        pending_symbols.push_back(8'h55);
        pending_symbols.push_back(8'd0);
        wait_drained();

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        for (int sp = 0; sp < 9; sp++) begin
            case (sp % 3)
                0: prior_pick = 16'($urandom_range(0, 65535));
                1: begin
                    case ($urandom_range(0, 2))
                        0: prior_pick = 16'h0000;
                        1: prior_pick = 16'h0001;
                        default: prior_pick = 16'hFFFF;
                    endcase
                end
                default: prior_pick = 16'($urandom_range(64, 1024));
            endcase
            case ($urandom_range(0, 2))
                0: active_pick = 16'd1;
                1: active_pick = 16'd256;
                default: active_pick = 16'($urandom_range(1, 256));
            endcase
            write_register(CFG_PRIOR_WEIGHT, prior_pick);
            write_register(CFG_ACTIVE_OUTCOMES, active_pick);
            send_idle_pct = (sp < 3) ? 20 : (sp < 6) ? 46 : 0;
            recv_idle_pct = (sp < 3) ? 46 : (sp < 6) ? 20 : 0;
            // Mostly a small hot set so counts grow; the rest spread over every index.
            hot_base = 8'($urandom_range(0, 255));
            repeat (150) begin
                if ($urandom_range(0, 99) < 70)
                    sym_draw = hot_base + 8'($urandom_range(0, 7));
                else
                    sym_draw = 8'($urandom_range(0, 255));
                pending_symbols.push_back(sym_draw);
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("dirichlet_symbol_predictor_tb passed");
        else
            $display("dirichlet_symbol_predictor_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("dirichlet_symbol_predictor_tb failed");
        $finish;
    end

endmodule
